// ----- hw/rtl/b64c_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_pkg: shared types and tables of the base64 stream codec
// Item and result structs, the group record passed from front to back, the
// mode code and the alphabet mapping functions.
// ----------------------------------------------------------------------------
package b64c_pkg;

  // Default depth of the group queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Pad character '='
  localparam logic [7:0] CHAR_PAD = 8'h3D;

  // Group record: up to four result bytes, first in slot 0
  localparam int GROUP_SLOTS = 4;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } b64c_mode_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_end;
  } b64c_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_end;
    logic       stream_end;
  } b64c_result_t;

  typedef struct packed {
    logic [GROUP_SLOTS-1:0][7:0] bytes;
    logic [2:0]                  count;
    logic                        last;
  } b64c_group_t;

  // Map a sextet to its character of the standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] s);
    logic [7:0] v;
    v = {2'b00, s};
    if (s < 6'd26) begin
      return v + 8'd65;
    end else if (s < 6'd52) begin
      return v + 8'd71;
    end else if (s < 6'd62) begin
      return v - 8'd4;
    end else if (s == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

  // Map a character to its sextet; anything outside the alphabet gives 255
  function automatic logic [7:0] sextet_of(input logic [7:0] c);
    if (c inside {[8'h41:8'h5A]}) begin
      return c - 8'd65;
    end else if (c inside {[8'h61:8'h7A]}) begin
      return c - 8'd71;
    end else if (c inside {[8'h30:8'h39]}) begin
      return c + 8'd4;
    end else if (c == 8'h2B) begin
      return 8'd62;
    end else if (c == 8'h2F) begin
      return 8'd63;
    end else begin
      return 8'd255;
    end
  endfunction

endpackage

// ----- hw/rtl/base64_stream_codec_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_unit: streaming base64 encoder and decoder
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+--------------------------------
//   item     | item_valid / item_ready    | data_byte, message_end
//   result   | result_valid / result_ready| out_byte, run_end, stream_end
//   config   | cfg_we                     | cfg_wdata (mode)
//
// An item is taken whenever the group queue has room; its group is written into
// the queue, and its first result then loads into the output register.
// The output port moves one result per cycle while result_ready is high; it
// limits encoding (three items, four results); decoding takes one item per cycle.
// Reset is synchronous: mode encode, open group empty, queue empty.
// A stalled result port fills the queue and then drops item_ready.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit #(
  parameter int QUEUE_DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_wdata,
  input  logic                   item_valid,
  output logic                   item_ready,
  input  b64c_pkg::b64c_item_t   item,
  output logic                   result_valid,
  input  logic                   result_ready,
  output b64c_pkg::b64c_result_t result
);
  import b64c_pkg::*;

  logic        q_ready;
  logic        q_push;
  b64c_group_t q_entry;
  logic        q_pop;
  logic        q_head_valid;
  b64c_group_t q_head;

  // Intake and group building
  b64c_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // Decouple front from back
  b64c_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  // Serialize groups to results
  b64c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (q_head_valid),
    .head         (q_head),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- hw/rtl/b64c_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_front: item intake and group builder
// Holds the mode and the open group, takes one item per cycle while the queue has
// room and turns each item into a group record of zero to four result bytes.
// ----------------------------------------------------------------------------
module b64c_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  b64c_pkg::b64c_item_t item,
  input  logic                q_ready,
  output logic                q_push,
  output b64c_pkg::b64c_group_t q_entry
);
  import b64c_pkg::*;

  b64c_mode_t  mode;
  logic [23:0] held_bits;
  logic [1:0]  fill_count;
  logic        padding_seen;

  logic [23:0] held_bits_next;
  logic [1:0]  fill_count_next;
  logic        padding_seen_next;
  b64c_group_t grp;

  logic [23:0] enc_word;
  logic [1:0]  enc_cnt;
  logic [7:0]  sextet;
  logic [23:0] dec_word;
  logic [1:0]  dec_cnt;
  logic        accept;

  // Bytes left by a partial decode group of c sextets
  function automatic b64c_group_t decode_flush(input logic [23:0] h, input logic [1:0] c);
    b64c_group_t g;
    g = '0;
    case (c)
      2'd2: begin
        g.bytes[0] = {h[11:6], h[5:4]};
        g.count    = 3'd1;
      end
      2'd3: begin
        g.bytes[0] = {h[17:12], h[11:10]};
        g.bytes[1] = {h[9:6], h[5:2]};
        g.count    = 3'd2;
      end
      default: begin
        g.count = 3'd0;
      end
    endcase
    return g;
  endfunction

  assign accept     = item_valid && item_ready;
  assign item_ready = q_ready;
  assign q_push     = accept && (grp.count != 3'd0);
  assign q_entry    = grp;

  // Classify the item and build its group
  always_comb begin
    held_bits_next    = held_bits;
    fill_count_next   = fill_count;
    padding_seen_next = padding_seen;
    grp               = '0;
    enc_word          = {held_bits[15:0], item.data_byte};
    enc_cnt           = fill_count + 2'd1;
    sextet            = sextet_of(item.data_byte);
    dec_word          = {held_bits[17:0], sextet[5:0]};
    dec_cnt           = fill_count + 2'd1;

    if (mode == MODE_ENCODE) begin
      if (enc_cnt == 2'd3) begin
        grp.bytes[0]    = b64_char(enc_word[23:18]);
        grp.bytes[1]    = b64_char(enc_word[17:12]);
        grp.bytes[2]    = b64_char(enc_word[11:6]);
        grp.bytes[3]    = b64_char(enc_word[5:0]);
        grp.count       = 3'd4;
        held_bits_next  = '0;
        fill_count_next = '0;
      end else begin
        held_bits_next  = enc_word;
        fill_count_next = enc_cnt;
        if (item.message_end) begin
          if (enc_cnt == 2'd1) begin
            grp.bytes[0] = b64_char(enc_word[7:2]);
            grp.bytes[1] = b64_char({enc_word[1:0], 4'b0000});
            grp.bytes[2] = CHAR_PAD;
          end else begin
            grp.bytes[0] = b64_char(enc_word[15:10]);
            grp.bytes[1] = b64_char(enc_word[9:4]);
            grp.bytes[2] = b64_char({enc_word[3:0], 2'b00});
          end
          grp.bytes[3] = CHAR_PAD;
          grp.count    = 3'd4;
        end
      end
    end else if (!padding_seen) begin
      if (item.data_byte == CHAR_PAD) begin
        // Pad flushes the open group, then ignore items to message end
        padding_seen_next = 1'b1;
        grp               = decode_flush(held_bits, fill_count);
        held_bits_next    = '0;
        fill_count_next   = '0;
      end else if (fill_count == 2'd3) begin
        grp.bytes[0]    = {held_bits[17:12], held_bits[11:10]};
        grp.bytes[1]    = {held_bits[9:6], held_bits[5:2]};
        grp.bytes[2]    = {held_bits[1:0], 6'b000000} + sextet;
        grp.count       = 3'd3;
        held_bits_next  = '0;
        fill_count_next = '0;
      end else begin
        held_bits_next  = dec_word;
        fill_count_next = dec_cnt;
        if (item.message_end) begin
          grp = decode_flush(dec_word, dec_cnt);
        end
      end
    end

    if (item.message_end) begin
      held_bits_next    = '0;
      fill_count_next   = '0;
      padding_seen_next = 1'b0;
    end
    grp.last = item.message_end;
  end

  // Hold mode and open group; a mode write clears the group, else advance on each accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_ENCODE;
      held_bits    <= '0;
      fill_count   <= '0;
      padding_seen <= 1'b0;
    end else if (cfg_we) begin
      mode         <= b64c_mode_t'(cfg_wdata);
      held_bits    <= '0;
      fill_count   <= '0;
      padding_seen <= 1'b0;
    end else if (accept) begin
      held_bits    <= held_bits_next;
      fill_count   <= fill_count_next;
      padding_seen <= padding_seen_next;
    end
  end

endmodule

// ----- hw/rtl/b64c_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_queue: group queue between front and back
// A small circular buffer of group records; the head is read in place.
// ----------------------------------------------------------------------------
module b64c_queue #(
  parameter int DEPTH = b64c_pkg::QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  b64c_pkg::b64c_group_t push_entry,
  output logic                  push_ready,
  input  logic                  pop,
  output logic                  head_valid,
  output b64c_pkg::b64c_group_t head
);
  import b64c_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  b64c_group_t      entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Store pushed groups
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + CNT_W'(1))
    else $error("push without pop did not grow the queue");
  a_entry_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> push_entry.count != 3'd0)
    else $error("empty group pushed");
`endif

endmodule

// ----- hw/rtl/b64c_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64c_back: result serializer
// Walks the head group one byte per cycle into the output register while it is
// free, marks the last byte of each group and flags the end of a message.
// ----------------------------------------------------------------------------
module b64c_back (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    head_valid,
  input  b64c_pkg::b64c_group_t   head,
  output logic                    pop,
  output logic                    result_valid,
  input  logic                    result_ready,
  output b64c_pkg::b64c_result_t  result
);
  import b64c_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       final_slot;

  assign load       = !result_valid || result_ready;
  assign final_slot = ({1'b0, idx} == (head.count - 3'd1));
  assign pop        = load && head_valid && final_slot;

  // Load the next byte whenever the output register is free
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        idx <= final_slot ? 2'd0 : idx + 2'd1;
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      result.out_byte   <= head.bytes[idx];
      result.run_end    <= final_slot;
      result.stream_end <= final_slot && head.last;
    end
  end

endmodule

// ----- tb/base64_stream_codec_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_stream_codec_unit_test: self-checking bench for the base64 codec
// Drives byte and character messages in both modes over the item channel with
// random gaps and result stalls, predicts every output item from a model of
// the codec state, and compares each result field by field in order.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit_test;
  import b64c_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_WAIT     = 17;
  localparam int PHASE_ITEMS  = 38;

  // Expected result store and codec state prediction
  class codec_scoreboard;
    string        alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    b64c_result_t expected_q[$];
    b64c_result_t burst[$];
    logic [23:0]  held_bits;
    int           fill;
    bit           pad_seen;
    b64c_mode_t   mode = MODE_ENCODE;
    int           failures;

    function int pending();
      return expected_q.size();
    endfunction

    // Mode write clears the open group
    function void set_mode(b64c_mode_t m);
      mode      = m;
      held_bits = '0;
      fill      = 0;
      pad_seen  = 0;
    endfunction

    function logic [7:0] char_of(logic [5:0] s);
      return alphabet[s];
    endfunction

    function logic [7:0] sextet_value(logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
        if (alphabet[i] == c) begin
          return i[7:0];
        end
      end
      return 8'hFF;
    endfunction

    function void emit(logic [7:0] v);
      b64c_result_t r;
      r.out_byte   = v;
      r.run_end    = 1'b0;
      r.stream_end = 1'b0;
      burst.push_back(r);
    endfunction

    // Flush a partial character group as one byte fewer than it holds
    function void flush_partial();
      logic [5:0] s0, s1, s2;
      if (fill == 2) begin
        s0 = held_bits[11:6];
        s1 = held_bits[5:0];
        emit({s0, s1[5:4]});
      end else if (fill == 3) begin
        s0 = held_bits[17:12];
        s1 = held_bits[11:6];
        s2 = held_bits[5:0];
        emit({s0, s1[5:4]});
        emit({s1[3:0], s2[5:2]});
      end
    endfunction

    // Work out the results of one accepted item
    function void note_item(b64c_item_t it);
      logic [23:0] g;
      logic [7:0]  v;
      logic [5:0]  s0, s1, s2;
      logic [5:0]  s;
      burst.delete();
      if (mode == MODE_ENCODE) begin
        held_bits = {held_bits[15:0], it.data_byte};
        fill++;
        if (fill == 3) begin
          for (int k = 0; k < 4; k++) begin
            s = 6'(held_bits >> (18 - 6 * k));
            emit(char_of(s));
          end
          held_bits = '0;
          fill      = 0;
        end else if (it.message_end) begin
          g = held_bits << (8 * (3 - fill));
          for (int k = 0; k < fill + 1; k++) begin
            s = 6'(g >> (18 - 6 * k));
            emit(char_of(s));
          end
          for (int k = fill; k < 3; k++) begin
            emit(CHAR_PAD);
          end
        end
      end else if (!pad_seen) begin
        if (it.data_byte == CHAR_PAD) begin
          pad_seen = 1;
          flush_partial();
          held_bits = '0;
          fill      = 0;
        end else begin
          v = sextet_value(it.data_byte);
          if (fill == 3) begin
            s0 = held_bits[17:12];
            s1 = held_bits[11:6];
            s2 = held_bits[5:0];
            emit({s0, s1[5:4]});
            emit({s1[3:0], s2[5:2]});
            // an out-of-alphabet fourth character adds its full value
            emit({s2[1:0], 6'b0} + v);
            held_bits = '0;
            fill      = 0;
          end else begin
            held_bits = {held_bits[17:0], v[5:0]};
            fill++;
          end
          if (it.message_end) begin
            flush_partial();
          end
        end
      end
      if (it.message_end) begin
        held_bits = '0;
        fill      = 0;
        pad_seen  = 0;
      end
      if (burst.size() > 0) begin
        burst[burst.size() - 1].run_end    = 1'b1;
        burst[burst.size() - 1].stream_end = it.message_end;
        foreach (burst[i]) begin
          expected_q.push_back(burst[i]);
        end
      end
    endfunction

    function void report(string what, b64c_result_t exp, b64c_result_t got);
      failures++;
      if (failures <= 10) begin
        $display("%s: expected %02h/%0b/%0b got %02h/%0b/%0b (byte/run_end/stream_end)",
                 what, exp.out_byte, exp.run_end, exp.stream_end,
                 got.out_byte, got.run_end, got.stream_end);
      end
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(b64c_result_t got);
      b64c_result_t exp;
      if (expected_q.size() == 0) begin
        exp = '0;
        report("unexpected result", exp, got);
        return;
      end
      exp = expected_q.pop_front();
      if (got.out_byte !== exp.out_byte || got.run_end !== exp.run_end ||
          got.stream_end !== exp.stream_end) begin
        report("result mismatch", exp, got);
      end
    endfunction
  endclass

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_wdata;
  logic         item_valid;
  logic         item_ready;
  b64c_item_t   item;
  logic         result_valid;
  logic         result_ready;
  b64c_result_t result;

  codec_scoreboard sb;
  int              cycles;
  int              send_calm;
  int              recv_calm;
  bit              reset_done;

  base64_stream_codec_unit dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Draw a wait, with occasional runs of back-to-back items
  function automatic int draw_wait(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(5, 20);
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // Receive results with random stalls
  initial begin
    int stall;
    result_ready = 1'b0;
    wait (reset_done);
    @(negedge clk);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        result_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      result_ready = 1'b1;
      do @(posedge clk); while (!(result_valid === 1'b1 && result_ready));
      sb.check_result(result);
      @(negedge clk);
    end
  end

  // Send one item and note it once accepted; call at a falling edge
  task automatic send_item(logic [7:0] b, logic last);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      item_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.data_byte   = b;
    item.message_end = last;
    item_valid       = 1'b1;
    do @(posedge clk); while (item_ready !== 1'b1);
    sb.note_item(item);
    @(negedge clk);
  endtask

  task automatic send_message(logic [7:0] text[$]);
    foreach (text[i]) begin
      send_item(text[i], i == text.size() - 1);
    end
  endtask

  // Wait until every expected result is out and the pipeline has drained
  task automatic wait_idle();
    item_valid = 1'b0;
    while (sb.pending() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(b64c_mode_t m);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_mode(m);
  endtask

  // Mostly valid base64 text with random content; the rest noise
  function automatic void build_decode_text(ref logic [7:0] text[$]);
    int n;
    int r;
    text.delete();
    if ($urandom_range(0, 9) < 7) begin
      n = $urandom_range(1, 3);
      for (int i = 0; i < 4 * n; i++) begin
        text.push_back(sb.alphabet[$urandom_range(0, 63)]);
      end
      case ($urandom_range(0, 3))
        1: text[text.size() - 1] = CHAR_PAD;
        2: begin
          text[text.size() - 1] = CHAR_PAD;
          text[text.size() - 2] = CHAR_PAD;
        end
        3: begin
          r = $urandom_range(1, 3);
          repeat (r) void'(text.pop_back());
        end
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
      end
    end else begin
      n = $urandom_range(1, 10);
      repeat (n) begin
        r = $urandom_range(0, 9);
        if (r < 6) begin
          text.push_back(sb.alphabet[$urandom_range(0, 63)]);
        end else if (r < 8) begin
          text.push_back(CHAR_PAD);
        end else begin
          text.push_back(8'($urandom_range(0, 255)));
        end
      end
    end
  endfunction

  function automatic void build_encode_text(ref logic [7:0] text[$]);
    int n;
    text.delete();
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 9);
    repeat (n) text.push_back(8'($urandom_range(0, 255)));
  endfunction

  // Main sequence
  initial begin
    logic [7:0] text[$];
    int         sent;
    b64c_mode_t m;
    sb           = new;
    cycles       = 0;
    send_calm    = 0;
    recv_calm    = 0;
    reset_done   = 0;
    rst          = 1'b1;
    cfg_we       = 1'b0;
    cfg_wdata    = 1'b0;
    item_valid   = 1'b0;
    item         = '0;
    repeat (8) @(negedge clk);
    rst        = 1'b0;
    reset_done = 1;

    // Directed encode: one, two and three byte endings, a full group plus one
    write_mode(MODE_ENCODE);
    text = '{8'h00};
    send_message(text);
    text = '{8'hFF, 8'hFF};
    send_message(text);
    text = '{8'h00, 8'hFF, 8'h80};
    send_message(text);
    text = '{8'h4D, 8'h61, 8'h6E, 8'hFF};
    send_message(text);

    // Directed decode: padding then an ignored item, unpadded flush of three,
    // lone character, out-of-alphabet characters in the middle and fourth place
    write_mode(MODE_DECODE);
    text = '{"T", "Q", CHAR_PAD, "A"};
    send_message(text);
    text = '{"T", "W", "E"};
    send_message(text);
    text = '{"Q"};
    send_message(text);
    text = '{"A", 8'h00, "A", 8'hFF};
    send_message(text);
    text = '{CHAR_PAD};
    send_message(text);

    // Random phases alternating the mode
    for (int p = 0; p < 5; p++) begin
      m = (p % 2 == 0) ? MODE_ENCODE : MODE_DECODE;
      write_mode(m);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if (m == MODE_ENCODE) begin
          build_encode_text(text);
        end else begin
          build_decode_text(text);
        end
        send_message(text);
        sent += text.size();
      end
    end

    // Drain and decide
    wait_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/b64c_pkg.sv
hw/rtl/b64c_front.sv
hw/rtl/b64c_queue.sv
hw/rtl/b64c_back.sv
hw/rtl/base64_stream_codec_unit.sv
tb/base64_stream_codec_unit_test.sv
